// File: rtl/core/pfdc_pkg.sv
`timescale 1ns / 1ps

package pfdc_pkg;

	// letter codes and square size
	localparam logic [4:0] LTR_X = 5'd23;
	localparam logic [4:0] LTR_J = 5'd9;
	localparam logic [4:0] LTR_I = 5'd8;
	localparam int SQ = 5;

	// configuration register indexes
	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_ROW0 = 3'd1;
	localparam logic [2:0] CFG_ROW1 = 3'd2;
	localparam logic [2:0] CFG_ROW2 = 3'd3;
	localparam logic [2:0] CFG_ROW3 = 3'd4;
	localparam logic [2:0] CFG_ROW4 = 3'd5;

	// reset square: A..Z without J, row-major
	localparam logic [24:0] KEY_ROW0_RST = 25'd4294688;
	localparam logic [24:0] KEY_ROW1_RST = 25'd10755269;
	localparam logic [24:0] KEY_ROW2_RST = 25'd16201099;
	localparam logic [24:0] KEY_ROW3_RST = 25'd21613104;
	localparam logic [24:0] KEY_ROW4_RST = 25'd27025109;

	typedef struct packed {
		logic [4:0] letter_code;
		logic       message_last;
	} item_t;

	typedef struct packed {
		logic [4:0] out_letter;
		logic       run_last;
		logic       message_end;
		logic       not_in_square;
	} res_t;

	// square: row, column, letter bits; column 0 in low bits of a row
	typedef logic [SQ-1:0][SQ-1:0][4:0] square_t;

	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
	} loc_t;

	typedef struct packed {
		logic [4:0] first;
		logic [4:0] second;
		logic       absent;
	} pair_out_t;

endpackage

// File: rtl/core/playfair_digraph_cipher_top.sv
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// item     | item_valid, item_ready | item_data (letter, message end)
// res      | res_valid, res_ready   | res_data (letter and flags)
// cfg      | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// an item is taken every cycle unless a pair in the pair register waits for
// the result buffer; a pair gives two results and a repeated letter at message
// end in encrypt mode four, one per cycle while res_ready is high, so a letter
// gives zero, two or four results. the first result passes through the pair
// register, then the result buffer. reset clears the held letter, selects
// encrypt and loads the square with A..Z without J. cfg_ready is always high.
module playfair_digraph_cipher_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pfdc_pkg::item_t     item_data,
	output logic                res_valid,
	input  logic                res_ready,
	output pfdc_pkg::res_t      res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [24:0]         cfg_data
);
	import pfdc_pkg::*;

	// find a letter, J as I; last match in row-major order wins
	function automatic loc_t locate(input logic [4:0] letter, input square_t sq);
		logic [4:0] l;
		loc_t       loc;
		l = (letter == LTR_J) ? LTR_I : letter;
		loc = '0;
		for (int i = 0; i < SQ; i++) begin
			for (int k = 0; k < SQ; k++) begin
				if (sq[i][k] == l) begin
					loc.found = 1'b1;
					loc.row = 3'(i);
					loc.col = 3'(k);
				end
			end
		end
		return loc;
	endfunction

	// step one place with wrap, forward or back
	function automatic logic [2:0] step(input logic [2:0] v, input logic back);
		logic [2:0] r;
		if (back)
			r = (v == 3'd0) ? 3'(SQ - 1) : v - 3'd1;
		else
			r = (v == 3'(SQ - 1)) ? 3'd0 : v + 3'd1;
		return r;
	endfunction

	// playfair rules on one pair
	function automatic pair_out_t transform(input logic [4:0] a, input logic [4:0] b,
			input logic back, input square_t sq);
		loc_t       la;
		loc_t       lb;
		logic [2:0] r1, c1, r2, c2;
		pair_out_t  po;
		la = locate(a, sq);
		lb = locate(b, sq);
		r1 = la.row;
		c1 = la.col;
		r2 = lb.row;
		c2 = lb.col;
		if (la.col == lb.col) begin
			r1 = step(la.row, back);
			r2 = step(lb.row, back);
		end else if (la.row == lb.row) begin
			c1 = step(la.col, back);
			c2 = step(lb.col, back);
		end else begin
			c1 = lb.col;
			c2 = la.col;
		end
		po.first = sq[r1][c1];
		po.second = sq[r2][c2];
		po.absent = !(la.found && lb.found);
		return po;
	endfunction

	// configuration registers
	logic    decrypt_q;
	square_t key_q;
	logic [2:0] row_sel;

	assign cfg_ready = 1'b1;
	assign row_sel = cfg_index - CFG_ROW0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			key_q[0] <= KEY_ROW0_RST;
			key_q[1] <= KEY_ROW1_RST;
			key_q[2] <= KEY_ROW2_RST;
			key_q[3] <= KEY_ROW3_RST;
			key_q[4] <= KEY_ROW4_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE: decrypt_q <= cfg_data[0];
				CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3, CFG_ROW4: begin
					key_q[row_sel] <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// pairing state and the pair register
	logic       holding_q;
	logic [4:0] held_q;
	logic       valid_s1;
	logic [1:0] npairs_s1;
	logic       last_s1;
	logic [4:0] a0_s1, b0_s1, a1_s1, b1_s1;

	logic       item_xfer;
	logic       s1_move;
	logic       buf_free;
	logic       res_xfer;

	// pairing decision for the incoming letter
	logic       same_letter;
	logic       pa_valid;
	logic [4:0] pa_b;
	logic       hold_mid;
	logic [4:0] held_mid;
	logic       pb_valid;
	logic [1:0] npairs;
	logic [4:0] a0, b0;

	always_comb begin
		same_letter = ((held_q == LTR_J) ? LTR_I : held_q) ==
			((item_data.letter_code == LTR_J) ? LTR_I : item_data.letter_code);
		pa_valid = holding_q;
		pa_b = item_data.letter_code;
		hold_mid = 1'b1;
		held_mid = item_data.letter_code;
		if (holding_q) begin
			if (!decrypt_q && same_letter) begin
				pa_b = LTR_X;
			end else begin
				hold_mid = 1'b0;
				held_mid = held_q;
			end
		end
		pb_valid = item_data.message_last && hold_mid;
		npairs = 2'({1'b0, pa_valid} + {1'b0, pb_valid});
		a0 = pa_valid ? held_q : held_mid;
		b0 = pa_valid ? pa_b : LTR_X;
	end

	assign res_xfer = res_valid && res_ready;
	assign s1_move = valid_s1 && ((npairs_s1 == 2'd0) || buf_free);
	assign item_ready = !valid_s1 || s1_move;
	assign item_xfer = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (item_xfer) begin
				holding_q <= hold_mid && !item_data.message_last;
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			held_q <= held_mid;
			npairs_s1 <= npairs;
			last_s1 <= item_data.message_last;
			a0_s1 <= a0;
			b0_s1 <= b0;
			a1_s1 <= held_mid;
			b1_s1 <= LTR_X;
		end
	end

	// cipher the pairs into the result buffer
	pair_out_t po0;
	pair_out_t po1;
	res_t      res_q [4];
	logic [1:0] rd_idx_q;
	logic [2:0] cnt_q;
	logic       load;

	assign po0 = transform(a0_s1, b0_s1, decrypt_q, key_q);
	assign po1 = transform(a1_s1, b1_s1, decrypt_q, key_q);
	assign buf_free = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && res_xfer);
	assign load = s1_move && (npairs_s1 != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= 2'd0;
			cnt_q <= 3'd0;
		end else if (load) begin
			rd_idx_q <= 2'd0;
			cnt_q <= {npairs_s1, 1'b0};
		end else if (res_xfer) begin
			rd_idx_q <= rd_idx_q + 2'd1;
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q[0] <= '{out_letter: po0.first, run_last: 1'b0, message_end: 1'b0,
				not_in_square: po0.absent};
			res_q[1] <= '{out_letter: po0.second, run_last: npairs_s1 == 2'd1,
				message_end: (npairs_s1 == 2'd1) && last_s1, not_in_square: po0.absent};
			res_q[2] <= '{out_letter: po1.first, run_last: 1'b0, message_end: 1'b0,
				not_in_square: po1.absent};
			res_q[3] <= '{out_letter: po1.second, run_last: 1'b1,
				message_end: last_s1, not_in_square: po1.absent};
		end
	end

	// result port
	assign res_valid = (cnt_q != 3'd0);
	assign res_data = res_q[rd_idx_q];

endmodule
